[rtl/core/tcb_pkg.sv]
`timescale 1ns / 1ps
package tcb_pkg;

    localparam int DEF_MAX_COLUMNS = 256;
    localparam int DEF_MAX_ROWS    = 64;

    localparam int TYPE_W  = 2;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 8;
    localparam int RWID_W  = 9;
    localparam int RHGT_W  = 7;
    localparam int GLYPH_W = 21;
    localparam int COLR_W  = 24;
    localparam int CNT_W   = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SCOLS_W = 9;
    localparam int SROWS_W = 7;

    localparam logic [TYPE_W-1:0] REQ_FILL = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_COPY = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_SET  = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_GET  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLUMNS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORE_COLOUR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOUR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FORE_IS_INDEX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_IS_INDEX  = 3'd5;

    localparam logic [GLYPH_W-1:0] BLANK = 21'h20;
    localparam logic [COLR_W-1:0]  WHITE = 24'hFFFFFF;
    localparam logic [COLR_W-1:0]  BLACK = 24'h000000;
    localparam logic [CNT_W-1:0]   CNT_MAX = 15'h7FFF;

    localparam logic [SCOLS_W-1:0] RST_COLUMNS = 9'd160;
    localparam logic [SROWS_W-1:0] RST_ROWS    = 7'd50;

endpackage

[rtl/core/tcb_in_if.sv]
`timescale 1ns / 1ps
interface tcb_in_if;
    logic                            valid;
    logic                            ready;
    logic [tcb_pkg::TYPE_W-1:0]      req_type;
    logic signed [tcb_pkg::COL_W-1:0] column;
    logic signed [tcb_pkg::ROW_W-1:0] row;
    logic [tcb_pkg::RWID_W-1:0]      rect_width;
    logic [tcb_pkg::RHGT_W-1:0]      rect_height;
    logic [tcb_pkg::GLYPH_W-1:0]     glyph;
    logic signed [tcb_pkg::COL_W-1:0] shift_columns;
    logic signed [tcb_pkg::ROW_W-1:0] shift_rows;

    modport source (output valid, req_type, column, row, rect_width, rect_height, glyph,
                    shift_columns, shift_rows, input ready);
    modport sink   (input valid, req_type, column, row, rect_width, rect_height, glyph,
                    shift_columns, shift_rows, output ready);
endinterface

[rtl/core/tcb_out_if.sv]
`timescale 1ns / 1ps
interface tcb_out_if;
    logic                          valid;
    logic                          ready;
    logic [tcb_pkg::CNT_W-1:0]     changed_cells;
    logic [tcb_pkg::CNT_W-1:0]     cleared_cells;
    logic [tcb_pkg::GLYPH_W-1:0]   read_glyph;
    logic [tcb_pkg::COLR_W-1:0]    read_fore;
    logic [tcb_pkg::COLR_W-1:0]    read_back;
    logic [1:0]                    read_flags;
    logic                          in_range;

    modport source (output valid, changed_cells, cleared_cells, read_glyph, read_fore,
                    read_back, read_flags, in_range, input ready);
    modport sink   (input valid, changed_cells, cleared_cells, read_glyph, read_fore,
                    read_back, read_flags, in_range, output ready);
endinterface

[rtl/core/text_cell_blitter_core.sv]
`timescale 1ns / 1ps
// character-cell screen store with rectangle fill, rectangle copy, cell set and cell get
// i_req: one request item per handshake; o_res: exactly one result item per request
// config: i_cfg_we / i_cfg_idx / i_cfg_data write one register per cycle; the user must
//   write only while idle, the block itself does not enforce it
// cells live in two single-port-write memories (glyph+flags, colours), registered read
// fill: per cell of the clamped rectangle, read destination, then compare and write
// copy: per cell whose destination is on screen, read source, read destination, then
//   compare and write; a cell whose destination is off screen is stepped over
// set, empty rectangle and off-screen get go from acceptance straight to the hand-off
// the result is valid in the cycle after the hand-off, when i_req.ready is high again
// copy walks the rectangle in the direction of the shift, so no source is overwritten
//   before it is read
// reset: a clearing pass writes a blank white-on-black cell into every one of the
//   MAX_COLUMNS*MAX_ROWS entries (16384 at the defaults); i_req.ready is low meanwhile
// receiver stall: the output register holds its item; the next request is still taken
//   and worked on, and its result waits until the output register frees up
module text_cell_blitter_core #(
    parameter int MAX_COLUMNS = tcb_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = tcb_pkg::DEF_MAX_ROWS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tcb_in_if.sink                            i_req,
    tcb_out_if.source                         o_res,
    input  logic                              i_cfg_we,
    input  logic [tcb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tcb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import tcb_pkg::*;

    localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CB    = $clog2(MAX_COLUMNS + 1);
    localparam int RB    = $clog2(MAX_ROWS + 1);
    localparam int CW    = ((CB > COL_W) ? CB : COL_W) + 2;
    localparam int RW    = ((RB > ROW_W) ? RB : ROW_W) + 2;
    localparam int GW    = GLYPH_W + 2;
    localparam int KW    = 2 * COLR_W;

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_SRC   = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_GET   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    // configuration
    logic [SCOLS_W-1:0] r_scr_cols;
    logic [SROWS_W-1:0] r_scr_rows;
    logic [COLR_W-1:0]  r_fore, r_back;
    logic               r_fore_idx, r_back_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_cols <= RST_COLUMNS;
            r_scr_rows <= RST_ROWS;
            r_fore     <= WHITE;
            r_back     <= BLACK;
            r_fore_idx <= 1'b0;
            r_back_idx <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCREEN_COLUMNS: r_scr_cols <= i_cfg_data[SCOLS_W-1:0];
                CFG_SCREEN_ROWS:    r_scr_rows <= i_cfg_data[SROWS_W-1:0];
                CFG_FORE_COLOUR:    r_fore     <= i_cfg_data[COLR_W-1:0];
                CFG_BACK_COLOUR:    r_back     <= i_cfg_data[COLR_W-1:0];
                CFG_FORE_IS_INDEX:  r_fore_idx <= i_cfg_data[0];
                CFG_BACK_IS_INDEX:  r_back_idx <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic signed [CW-1:0] act_c;
    logic signed [RW-1:0] act_r;
    always_comb begin
        act_c = $signed(CW'(r_scr_cols));
        if (act_c > $signed(CW'(MAX_COLUMNS))) act_c = $signed(CW'(MAX_COLUMNS));
        act_r = $signed(RW'(r_scr_rows));
        if (act_r > $signed(RW'(MAX_ROWS))) act_r = $signed(RW'(MAX_ROWS));
    end

    // memories
    logic [GW-1:0] mem_g [CELLS];
    logic [KW-1:0] mem_k [CELLS];
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [GW-1:0] mem_wg, rd_g;
    logic [KW-1:0] mem_wk, rd_k;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_g[mem_wa] <= mem_wg;
            mem_k[mem_wa] <= mem_wk;
        end
        if (mem_re) begin
            rd_g <= mem_g[mem_ra];
            rd_k <= mem_k[mem_ra];
        end
    end

    // control and work registers
    logic [2:0]           r_state, n_state;
    logic [AW-1:0]        r_clr_idx;
    logic signed [CW-1:0] r_xs, r_xe, r_c, r_tx;
    logic signed [RW-1:0] r_ys, r_ye, r_r, r_ty;
    logic                 r_desc, r_copy;
    logic [GW-1:0]        r_new_g;
    logic [KW-1:0]        r_new_k;
    logic [CNT_W-1:0]     r_chg, r_clr;
    logic [GLYPH_W-1:0]   r_rg;
    logic [COLR_W-1:0]    r_rf, r_rb;
    logic [1:0]           r_fl;
    logic                 r_inr;
    logic                 r_o_valid;
    logic [CNT_W-1:0]     r_o_chg, r_o_clr;
    logic [GLYPH_W-1:0]   r_o_rg;
    logic [COLR_W-1:0]    r_o_rf, r_o_rb;
    logic [1:0]           r_o_fl;
    logic                 r_o_inr;

    function automatic logic [AW-1:0] cell_addr(input logic signed [CW-1:0] c,
                                                input logic signed [RW-1:0] r);
        cell_addr = AW'(AW'(r) * AW'(MAX_COLUMNS)) + AW'(c);
    endfunction

    // request decode
    logic signed [CW-1:0] in_col, in_x, in_w, lim_c;
    logic signed [RW-1:0] in_row, in_y, in_h, lim_r;
    logic signed [CW-1:0] in_tx;
    logic signed [RW-1:0] in_ty;
    logic                 in_empty, in_on, accept;
    logic [GW-1:0]        cur_g;
    logic [KW-1:0]        cur_k;

    always_comb begin
        in_col = CW'(i_req.column);
        in_row = RW'(i_req.row);
        in_tx  = CW'(i_req.shift_columns);
        in_ty  = RW'(i_req.shift_rows);
        in_x   = in_col - CW'(1);
        if (in_x < 0) in_x = '0;
        in_y   = in_row - RW'(1);
        if (in_y < 0) in_y = '0;
        lim_c  = act_c - in_x;
        lim_r  = act_r - in_y;
        in_w   = $signed(CW'(i_req.rect_width));
        if (in_w > lim_c) in_w = lim_c;
        in_h   = $signed(RW'(i_req.rect_height));
        if (in_h > lim_r) in_h = lim_r;
        in_empty = (in_w <= 0) || (in_h <= 0);
        in_on  = (in_col >= CW'(1)) && (in_row >= RW'(1))
                 && (in_col <= act_c) && (in_row <= act_r);
        cur_g  = {r_back_idx, r_fore_idx, i_req.glyph};
        cur_k  = {r_back, r_fore};
    end

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // cell walk
    logic signed [CW-1:0] dst_c, nxt_c;
    logic signed [RW-1:0] dst_r, nxt_r;
    logic                 dst_on, last;
    always_comb begin
        dst_c  = r_copy ? r_c + r_tx : r_c;
        dst_r  = r_copy ? r_r + r_ty : r_r;
        dst_on = (dst_c >= 0) && (dst_r >= 0) && (dst_c < act_c) && (dst_r < act_r);
        nxt_c  = r_c;
        nxt_r  = r_r;
        if (r_desc) begin
            last = (r_c == r_xs) && (r_r == r_ys);
            if (r_c == r_xs) begin
                nxt_c = r_xe;
                nxt_r = r_r - RW'(1);
            end else begin
                nxt_c = r_c - CW'(1);
            end
        end else begin
            last = (r_c == r_xe) && (r_r == r_ye);
            if (r_c == r_xe) begin
                nxt_c = r_xs;
                nxt_r = r_r + RW'(1);
            end else begin
                nxt_c = r_c + CW'(1);
            end
        end
    end

    logic differs, out_free;
    assign differs  = (rd_g != r_new_g) || (rd_k != r_new_k);
    assign out_free = !r_o_valid || o_res.ready;

    // memory port selection
    always_comb begin
        mem_we = 1'b0;
        mem_wa = cell_addr(dst_c, dst_r);
        mem_wg = r_new_g;
        mem_wk = r_new_k;
        mem_re = 1'b0;
        mem_ra = cell_addr(dst_c, dst_r);
        unique case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
                mem_wa = r_clr_idx;
                mem_wg = {2'b00, BLANK};
                mem_wk = {BLACK, WHITE};
            end
            S_IDLE: begin
                mem_wa = cell_addr(in_col - CW'(1), in_row - RW'(1));
                mem_ra = mem_wa;
                mem_wg = cur_g;
                mem_wk = cur_k;
                mem_we = accept && in_on && (i_req.req_type == REQ_SET);
                mem_re = accept && in_on && (i_req.req_type == REQ_GET);
            end
            S_ISSUE: begin
                mem_re = dst_on;
                if (r_copy) mem_ra = cell_addr(r_c, r_r);
            end
            S_SRC:   mem_re = 1'b1;
            S_CMP:   mem_we = differs;
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:   if (r_clr_idx == AW'(CELLS - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req.req_type)
                        REQ_FILL, REQ_COPY: n_state = in_empty ? S_FIN : S_ISSUE;
                        REQ_SET:            n_state = S_FIN;
                        default:            n_state = in_on ? S_GET : S_FIN;
                    endcase
                end
            end
            S_ISSUE: begin
                if (dst_on)    n_state = r_copy ? S_SRC : S_CMP;
                else if (last) n_state = S_FIN;
            end
            S_SRC:   n_state = S_CMP;
            S_CMP:   n_state = last ? S_FIN : S_ISSUE;
            S_GET:   n_state = S_FIN;
            S_FIN:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_idx <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_clr_idx <= r_clr_idx + AW'(1);
            if (r_state == S_FIN && out_free) r_o_valid <= 1'b1;
            else if (o_res.ready)             r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_chg  <= '0;
            r_clr  <= '0;
            r_rg   <= '0;
            r_rf   <= '0;
            r_rb   <= '0;
            r_fl   <= '0;
            r_inr  <= (i_req.req_type == REQ_SET || i_req.req_type == REQ_GET) && in_on;
            r_copy <= (i_req.req_type == REQ_COPY);
            r_desc <= (i_req.req_type == REQ_COPY)
                      && ((in_ty > 0) || ((in_ty == 0) && (in_tx > 0)));
            r_xs   <= in_x;
            r_xe   <= in_x + in_w - CW'(1);
            r_ys   <= in_y;
            r_ye   <= in_y + in_h - RW'(1);
            r_tx   <= in_tx;
            r_ty   <= in_ty;
            r_new_g <= cur_g;
            r_new_k <= cur_k;
            if ((i_req.req_type == REQ_COPY)
                && ((in_ty > 0) || ((in_ty == 0) && (in_tx > 0)))) begin
                r_c <= in_x + in_w - CW'(1);
                r_r <= in_y + in_h - RW'(1);
            end else begin
                r_c <= in_x;
                r_r <= in_y;
            end
        end
        if (r_state == S_ISSUE && !dst_on) begin
            r_c <= nxt_c;
            r_r <= nxt_r;
        end
        if (r_state == S_SRC) begin
            r_new_g <= rd_g;
            r_new_k <= rd_k;
        end
        if (r_state == S_CMP) begin
            r_c <= nxt_c;
            r_r <= nxt_r;
            if (differs) begin
                if (r_new_g[GLYPH_W-1:0] == BLANK) begin
                    if (r_clr != CNT_MAX) r_clr <= r_clr + CNT_W'(1);
                end else begin
                    if (r_chg != CNT_MAX) r_chg <= r_chg + CNT_W'(1);
                end
            end
        end
        if (r_state == S_GET) begin
            r_rg <= rd_g[GLYPH_W-1:0];
            r_fl <= rd_g[GW-1:GLYPH_W];
            r_rf <= rd_k[COLR_W-1:0];
            r_rb <= rd_k[KW-1:COLR_W];
        end
        if (r_state == S_FIN && out_free) begin
            r_o_chg <= r_chg;
            r_o_clr <= r_clr;
            r_o_rg  <= r_rg;
            r_o_rf  <= r_rf;
            r_o_rb  <= r_rb;
            r_o_fl  <= r_fl;
            r_o_inr <= r_inr;
        end
    end

    assign o_res.valid         = r_o_valid;
    assign o_res.changed_cells = r_o_chg;
    assign o_res.cleared_cells = r_o_clr;
    assign o_res.read_glyph    = r_o_rg;
    assign o_res.read_fore     = r_o_rf;
    assign o_res.read_back     = r_o_rb;
    assign o_res.read_flags    = r_o_fl;
    assign o_res.in_range      = r_o_inr;

    a_no_req_during_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !i_req.ready)
        else $error("request taken during clearing pass");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_CLR || r_state == S_IDLE || r_state == S_CMP))
        else $error("memory write outside a write state");

    a_cell_no_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.in_range) |-> (o_res.changed_cells == '0
                                             && o_res.cleared_cells == '0))
        else $error("set or get item carries counts");

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free) |=> o_res.valid)
        else $error("finished item not presented");

endmodule

[sim/text_cell_blitter_core_test.sv]
`timescale 1ns / 1ps
module text_cell_blitter_core_test;
    import tcb_pkg::*;

    localparam int NCOLS = DEF_MAX_COLUMNS;
    localparam int NROWS = DEF_MAX_ROWS;
    localparam int NCELLS = NCOLS * NROWS;
    localparam int CYCLE_LIMIT = 6000000;

    typedef struct {
        logic [TYPE_W-1:0]        kind;
        logic signed [COL_W-1:0]  column;
        logic signed [ROW_W-1:0]  row;
        logic [RWID_W-1:0]        width;
        logic [RHGT_W-1:0]        height;
        logic [GLYPH_W-1:0]       glyph;
        logic signed [COL_W-1:0]  shift_col;
        logic signed [ROW_W-1:0]  shift_row;
    } cell_req_t;

    typedef struct packed {
        logic [CNT_W-1:0]   changed;
        logic [CNT_W-1:0]   cleared;
        logic [GLYPH_W-1:0] glyph;
        logic [COLR_W-1:0]  fore;
        logic [COLR_W-1:0]  back;
        logic [1:0]         flags;
        logic               in_range;
    } cell_res_t;

    class screen_scoreboard;
        logic [GLYPH_W+1:0]  glyphs[NCELLS];
        logic [2*COLR_W-1:0] colours[NCELLS];
        logic [GLYPH_W+1:0]  snap_glyphs[NCELLS];
        logic [2*COLR_W-1:0] snap_colours[NCELLS];
        logic [SCOLS_W-1:0]  scr_cols;
        logic [SROWS_W-1:0]  scr_rows;
        logic [COLR_W-1:0]   fore, back;
        logic                fore_idx, back_idx;
        cell_res_t           pending[$];
        int                  errors;
        int                  kind_count[4];

        function new();
            for (int i = 0; i < NCELLS; i++) begin
                glyphs[i] = {2'b00, BLANK};
                colours[i] = {BLACK, WHITE};
            end
            scr_cols = RST_COLUMNS;
            scr_rows = RST_ROWS;
            fore = WHITE;
            back = BLACK;
            fore_idx = 0;
            back_idx = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_SCREEN_COLUMNS: scr_cols = val[SCOLS_W-1:0];
                CFG_SCREEN_ROWS:    scr_rows = val[SROWS_W-1:0];
                CFG_FORE_COLOUR:    fore = val;
                CFG_BACK_COLOUR:    back = val;
                CFG_FORE_IS_INDEX:  fore_idx = val[0];
                CFG_BACK_IS_INDEX:  back_idx = val[0];
                default: ;
            endcase
        endfunction

        function int act_cols();
            return (scr_cols > NCOLS) ? NCOLS : int'(scr_cols);
        endfunction

        function int act_rows();
            return (scr_rows > NROWS) ? NROWS : int'(scr_rows);
        endfunction

        function bit visible(int c, int r);
            return c >= 0 && r >= 0 && c < act_cols() && r < act_rows();
        endfunction

        function void note(cell_req_t q);
            cell_res_t           res;
            logic [GLYPH_W+1:0]  cur_g, ng;
            logic [2*COLR_W-1:0] cur_c, nc;
            int x, y, w, h, d, s;
            res = '{default: '0};
            cur_g = {back_idx, fore_idx, q.glyph};
            cur_c = {back, fore};
            kind_count[q.kind]++;
            if (q.kind == REQ_FILL || q.kind == REQ_COPY) begin
                x = int'(q.column) - 1;
                if (x < 0) x = 0;
                w = int'(q.width);
                if (w > act_cols() - x) w = act_cols() - x;
                y = int'(q.row) - 1;
                if (y < 0) y = 0;
                h = int'(q.height);
                if (h > act_rows() - y) h = act_rows() - y;
                if (q.kind == REQ_COPY) begin
                    snap_glyphs = glyphs;
                    snap_colours = colours;
                end
                for (int cx = x; cx < x + w; cx++) begin
                    for (int cy = y; cy < y + h; cy++) begin
                        if (q.kind == REQ_FILL) begin
                            d = cy * NCOLS + cx;
                            ng = cur_g;
                            nc = cur_c;
                        end else begin
                            if (!visible(cx + int'(q.shift_col), cy + int'(q.shift_row)))
                                continue;
                            s = cy * NCOLS + cx;
                            d = (cy + int'(q.shift_row)) * NCOLS + cx + int'(q.shift_col);
                            ng = snap_glyphs[s];
                            nc = snap_colours[s];
                        end
                        if (glyphs[d] != ng || colours[d] != nc) begin
                            glyphs[d] = ng;
                            colours[d] = nc;
                            if (ng[GLYPH_W-1:0] == BLANK) begin
                                if (res.cleared != CNT_MAX) res.cleared++;
                            end else if (res.changed != CNT_MAX) begin
                                res.changed++;
                            end
                        end
                    end
                end
            end else if (visible(int'(q.column) - 1, int'(q.row) - 1)) begin
                d = (int'(q.row) - 1) * NCOLS + int'(q.column) - 1;
                res.in_range = 1;
                if (q.kind == REQ_SET) begin
                    glyphs[d] = cur_g;
                    colours[d] = cur_c;
                end else begin
                    res.glyph = glyphs[d][GLYPH_W-1:0];
                    res.flags = glyphs[d][GLYPH_W+1:GLYPH_W];
                    res.fore = colours[d][COLR_W-1:0];
                    res.back = colours[d][2*COLR_W-1:COLR_W];
                end
            end
            pending.push_back(res);
        endfunction

        function void check(cell_res_t got);
            cell_res_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item at %0t", $realtime);
                return;
            end
            want = pending.pop_front();
            if (got != want) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch at %0t: exp chg %0d clr %0d g %h f %h b %h fl %b in %b,",
                              " got chg %0d clr %0d g %h f %h b %h fl %b in %b"}, $realtime,
                             want.changed, want.cleared, want.glyph, want.fore, want.back,
                             want.flags, want.in_range, got.changed, got.cleared, got.glyph,
                             got.fore, got.back, got.flags, got.in_range);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    tcb_in_if  req_if ();
    tcb_out_if res_if ();

    text_cell_blitter_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if.sink),
        .o_res      (res_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    screen_scoreboard sb = new();
    bit quiet = 0;
    bit long_hold = 0;
    int cycles = 0;
    int settings_seen = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout, %0d results outstanding", sb.pending.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        int stall_left;
        logic nxt;
        stall_left = 0;
        res_if.ready = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready)
                sb.check('{res_if.changed_cells, res_if.cleared_cells, res_if.read_glyph,
                           res_if.read_fore, res_if.read_back, res_if.read_flags,
                           res_if.in_range});
            if (long_hold) begin
                long_hold = 0;
                stall_left = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                nxt = 0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                nxt = 0;
            end else begin
                nxt = 1;
            end
            res_if.ready <= nxt;
        end
    end

    task automatic send(cell_req_t q);
        req_if.valid <= 1;
        req_if.req_type <= q.kind;
        req_if.column <= q.column;
        req_if.row <= q.row;
        req_if.rect_width <= q.width;
        req_if.rect_height <= q.height;
        req_if.glyph <= q.glyph;
        req_if.shift_columns <= q.shift_col;
        req_if.shift_rows <= q.shift_row;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note(q);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            req_if.valid <= 0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        req_if.valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic setup_screen(int cols, int rows, logic [23:0] fg, logic [23:0] bg,
                                bit fi, bit bi);
        drain();
        cfg_write(CFG_SCREEN_COLUMNS, CFG_DATA_W'(cols));
        cfg_write(CFG_SCREEN_ROWS, CFG_DATA_W'(rows));
        cfg_write(CFG_FORE_COLOUR, fg);
        cfg_write(CFG_BACK_COLOUR, bg);
        cfg_write(CFG_FORE_IS_INDEX, CFG_DATA_W'(fi));
        cfg_write(CFG_BACK_IS_INDEX, CFG_DATA_W'(bi));
        i_cfg_we <= 0;
        settings_seen++;
    endtask

    function automatic cell_req_t mk(logic [1:0] k, int c, int r, int w, int h, int g,
                                     int sx = 0, int sy = 0);
        cell_req_t q;
        q.kind = k;
        q.column = COL_W'(c);
        q.row = ROW_W'(r);
        q.width = RWID_W'(w);
        q.height = RHGT_W'(h);
        q.glyph = GLYPH_W'(g);
        q.shift_col = COL_W'(sx);
        q.shift_row = ROW_W'(sy);
        return q;
    endfunction

    function automatic cell_req_t rand_req(int ac, int ar);
        cell_req_t q;
        int sel;
        q = mk(2'($urandom_range(0, 3)), $urandom_range(0, ac + 2), $urandom_range(0, ar + 2),
               $urandom_range(0, 8), $urandom_range(0, 6), $urandom_range(33, 126),
               int'($urandom_range(0, 8)) - 4, int'($urandom_range(0, 6)) - 3);
        sel = $urandom_range(0, 19);
        if (sel == 0) q.column = COL_W'($urandom);
        if (sel == 1) q.row = ROW_W'($urandom);
        if (sel == 2) q.shift_col = COL_W'($urandom);
        if (sel == 3) q.shift_row = ROW_W'($urandom);
        if (sel == 4) q.width = RWID_W'($urandom);
        if (sel == 5) q.height = RHGT_W'($urandom);
        if (sel >= 6 && sel <= 8) q.glyph = BLANK;
        if (sel == 9) q.glyph = GLYPH_W'($urandom);
        if (sel == 10) begin
            q.width = RWID_W'($urandom_range(0, 40));
            q.height = RHGT_W'($urandom_range(0, 20));
        end
        return q;
    endfunction

    initial begin
        int ac, ar;
        req_if.valid = 0;
        req_if.req_type = REQ_FILL;
        req_if.column = 0;
        req_if.row = 0;
        req_if.rect_width = 0;
        req_if.rect_height = 0;
        req_if.glyph = 0;
        req_if.shift_columns = 0;
        req_if.shift_rows = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reset screen, corners, off-screen cells, clamps, overlap
        send(mk(REQ_GET, 1, 1, 0, 0, 0));
        send(mk(REQ_SET, 1, 1, 0, 0, 'h41));
        send(mk(REQ_SET, 160, 50, 0, 0, 'h1FFFFF));
        send(mk(REQ_SET, 0, 0, 0, 0, 'h42));
        send(mk(REQ_SET, -256, -64, 0, 0, 'h42));
        send(mk(REQ_GET, 257, 65, 0, 0, 0));
        send(mk(REQ_GET, 161, 1, 0, 0, 0));
        send(mk(REQ_GET, 160, 50, 0, 0, 0));
        send(mk(REQ_FILL, -5, -3, 10, 6, 'h58));
        send(mk(REQ_FILL, 155, 47, 20, 20, 'h59));
        send(mk(REQ_FILL, 3, 3, 0, 5, 'h5A));
        send(mk(REQ_FILL, 3, 3, 5, 5, BLANK));
        send(mk(REQ_COPY, 1, 1, 6, 4, 0, 1, 1));
        send(mk(REQ_COPY, 2, 2, 6, 4, 0, -1, -1));
        send(mk(REQ_COPY, 150, 45, 10, 6, 0, 5, 3));
        send(mk(REQ_COPY, 1, 1, 4, 4, 0, -256, 64));
        send(mk(REQ_GET, 2, 2, 0, 0, 0));
        send(mk(REQ_GET, 156, 48, 0, 0, 0));
        setup_screen(511, 127, 24'h000000, 24'hFFFFFF, 1, 1);
        send(mk(REQ_FILL, 1, 1, 511, 127, 'h23));
        send(mk(REQ_FILL, 1, 1, 511, 127, 'h23));
        send(mk(REQ_GET, 256, 64, 0, 0, 0));
        send(mk(REQ_COPY, 1, 1, 511, 127, 0, 255, 63));
        setup_screen(0, 0, 24'h123456, 24'h654321, 0, 1);
        send(mk(REQ_FILL, 1, 1, 10, 10, 'h41));
        send(mk(REQ_SET, 1, 1, 0, 0, 'h41));

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: setup_screen(160, 50, 24'hFFFFFF, 24'h000000, 0, 0);
                1: setup_screen(1, 1, 24'($urandom), 24'($urandom), 1, 0);
                2: setup_screen(256, 64, 24'($urandom), 24'($urandom), 0, 1);
                3: setup_screen($urandom_range(1, 40), $urandom_range(1, 20), 24'h0, 24'h0, 1, 1);
                4: setup_screen(300, 100, 24'($urandom), 24'($urandom), 1, 0);
                5: setup_screen(24, 12, 24'($urandom), 24'hFFFFFF, 0, 0);
                6: setup_screen(12, 6, 24'($urandom), 24'($urandom), 1, 1);
                default: setup_screen(32, 16, 24'($urandom), 24'($urandom), 0, 1);
            endcase
            ac = sb.act_cols();
            ar = sb.act_rows();
            if (ph == 7) quiet = 1;
            for (int n = 0; n < 70; n++) begin
                if (ph == 2 && n == 10) long_hold = 1;
                if (ph == 5 && n == 30) drain();
                if (n % 7 == 3 && !quiet) begin
                    // toggle colours mid-phase through idle writes so fills differ
                    drain();
                    cfg_write(CFG_FORE_COLOUR, CFG_DATA_W'($urandom));
                    cfg_write(CFG_FORE_IS_INDEX, CFG_DATA_W'($urandom_range(0, 1)));
                    i_cfg_we <= 0;
                end
                send(rand_req(ac, ar));
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        $display("covered %0d fills, %0d copies, %0d sets, %0d gets",
                 sb.kind_count[REQ_FILL], sb.kind_count[REQ_COPY],
                 sb.kind_count[REQ_SET], sb.kind_count[REQ_GET]);
        $display("over %0d screen and colour settings, %0d mismatches",
                 settings_seen, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
